>>> src/cdad_pkg.sv
// Shared types, constants and calendar helpers for the date register block.
`timescale 1ns / 1ps
package cdad_pkg;

  localparam logic [15:0] BASE_YEAR  = 16'd2000;
  localparam logic [15:0] TOP_YEAR   = 16'd65535;
  localparam logic [15:0] YEAR_CYCLE = 16'd400;   // Gregorian rule repeats every 400 years
  localparam logic [8:0]  CYCLE_LAST = 9'd399;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [4:0]  DAY_MAX    = 5'd31;
  localparam int          RED_STEPS  = 8;         // 400 << 7 is the largest step below 2^16
  localparam int          RED_W      = $clog2(RED_STEPS);

  // Microprogram step addresses
  typedef enum logic [2:0] {
    S_WAIT     = 3'd0,
    S_DISPATCH = 3'd1,
    S_REDUCE   = 3'd2,
    S_CLAMP    = 3'd3,
    S_WALK     = 3'd4,
    S_EMIT     = 3'd5,
    S_DONE     = 3'd6
  } step_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_LATCH  = 3'd1,
    OP_REDUCE = 3'd2,
    OP_CLAMP  = 3'd3,
    OP_WALK   = 3'd4,
    OP_EMIT   = 3'd5
  } dp_op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_IDLE     = 3'd2,
    C_ADD      = 3'd3,
    C_RED_MORE = 3'd4,
    C_NOT_FITS = 3'd5,
    C_OUT_BUSY = 3'd6
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
  } ctrl_word_t;

  typedef struct packed {
    logic idle;
    logic is_add;
    logic red_more;
    logic not_fits;
    logic out_busy;
  } dp_stat_t;

  // Leap test on the year modulo 400
  function automatic logic is_leap(input logic [8:0] ym);
    is_leap = (ym == 9'd0) ||
              ((ym[1:0] == 2'b00) && (ym != 9'd100) && (ym != 9'd200) && (ym != 9'd300));
  endfunction

  // Month length in days
  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    case (m)
      4'd2:                      days_in = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   days_in = 5'd30;
      default:                   days_in = 5'd31;
    endcase
  endfunction

endpackage

>>> src/cdad_if.sv
// Valid/ready channel interfaces for date items and date results.
`timescale 1ns / 1ps
interface cdad_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] set_year;
  logic [7:0]  set_month;
  logic [7:0]  set_day;
  logic [15:0] add_count;

  modport source (output valid, opcode, set_year, set_month, set_day, add_count,
                  input ready);
  modport sink   (input valid, opcode, set_year, set_month, set_day, add_count,
                  output ready);
endinterface

interface cdad_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;

  modport source (output valid, out_year, out_month, out_day, input ready);
  modport sink   (input valid, out_year, out_month, out_day, output ready);
endinterface

>>> src/cdad_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps
module cdad_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cdad_pkg::dp_stat_t    stat,
  output cdad_pkg::ctrl_word_t  ctrl
);
  import cdad_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  take;

  // Control store
  always_comb begin
    case (step_r)
      S_WAIT:     ctrl = '{op: OP_LATCH,  cond: C_IDLE,     target: S_WAIT};
      S_DISPATCH: ctrl = '{op: OP_NOP,    cond: C_ADD,      target: S_WALK};
      S_REDUCE:   ctrl = '{op: OP_REDUCE, cond: C_RED_MORE, target: S_REDUCE};
      S_CLAMP:    ctrl = '{op: OP_CLAMP,  cond: C_ALWAYS,   target: S_EMIT};
      S_WALK:     ctrl = '{op: OP_WALK,   cond: C_NOT_FITS, target: S_WALK};
      S_EMIT:     ctrl = '{op: OP_EMIT,   cond: C_OUT_BUSY, target: S_EMIT};
      S_DONE:     ctrl = '{op: OP_NOP,    cond: C_ALWAYS,   target: S_WAIT};
      default:    ctrl = '{op: OP_NOP,    cond: C_ALWAYS,   target: S_WAIT};
    endcase
  end

  // Evaluate the jump condition
  always_comb begin
    case (ctrl.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_IDLE:     take = stat.idle;
      C_ADD:      take = stat.is_add;
      C_RED_MORE: take = stat.red_more;
      C_NOT_FITS: take = stat.not_fits;
      C_OUT_BUSY: take = stat.out_busy;
      default:    take = 1'b1;
    endcase
  end

  // Jump or advance
  always_comb begin
    if (take) begin
      step_nxt = ctrl.target;
    end else begin
      step_nxt = step_t'(step_r + 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> src/cdad_dp.sv
// Date datapath: stored date, year-mod-400 tracker, month walker and output register.
`timescale 1ns / 1ps
module cdad_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cdad_pkg::ctrl_word_t  ctrl,
  output cdad_pkg::dp_stat_t    stat,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [15:0]           in_set_year,
  input  logic [7:0]            in_set_month,
  input  logic [7:0]            in_set_day,
  input  logic [15:0]           in_add_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_year,
  output logic [3:0]            out_month,
  output logic [4:0]            out_day
);
  import cdad_pkg::*;

  logic [15:0]      year_r,  year_nxt;
  logic [15:0]      ymod_r,  ymod_nxt;
  logic [3:0]       month_r, month_nxt;
  logic [16:0]      day_r,   day_nxt;
  logic [RED_W-1:0] k_r,     k_nxt;
  logic             add_r,   add_nxt;
  logic             ov_r,    ov_nxt;
  logic [15:0]      oy_r,    oy_nxt;
  logic [3:0]       om_r,    om_nxt;
  logic [4:0]       od_r,    od_nxt;

  logic        fire;
  logic        leap;
  logic [4:0]  len;
  logic        not_fits;
  logic        out_busy;
  logic [16:0] red_sub;
  logic [15:0] year_clamped;
  logic [8:0]  ymod_low;

  assign in_ready     = (ctrl.op == OP_LATCH);
  assign fire         = in_valid && in_ready;
  assign ymod_low     = ymod_r[8:0];
  assign leap         = is_leap(ymod_low);
  assign len          = days_in(month_r, leap);
  assign not_fits     = day_r > {12'd0, len};
  assign out_busy     = ov_r && !out_ready;
  assign red_sub      = {1'b0, YEAR_CYCLE} << k_r;
  assign year_clamped = (in_set_year < BASE_YEAR) ? BASE_YEAR : in_set_year;

  assign stat = '{idle: !fire, is_add: add_r, red_more: (k_r != '0),
                  not_fits: not_fits, out_busy: out_busy};

  always_comb begin
    year_nxt  = year_r;
    ymod_nxt  = ymod_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    k_nxt     = k_r;
    add_nxt   = add_r;
    oy_nxt    = oy_r;
    om_nxt    = om_r;
    od_nxt    = od_r;
    // drop the result once the sink takes it
    ov_nxt    = ov_r && !out_ready;
    case (ctrl.op)
      // take a beat: load a date with year and month clamped, or form the day sum
      OP_LATCH: begin
        if (fire) begin
          add_nxt = in_opcode;
          if (in_opcode) begin
            day_nxt = day_r + {1'b0, in_add_count};
          end else begin
            year_nxt  = year_clamped;
            ymod_nxt  = year_clamped;
            month_nxt = ((in_set_month == 8'd0) || (in_set_month > {4'd0, MONTH_MAX}))
                        ? 4'd1 : in_set_month[3:0];
            day_nxt   = {9'd0, in_set_day};
            k_nxt     = RED_W'(RED_STEPS - 1);
          end
        end
      end
      // restoring reduction of the year modulo 400, one shifted step per cycle
      OP_REDUCE: begin
        if ({1'b0, ymod_r} >= red_sub) begin
          ymod_nxt = ymod_r - red_sub[15:0];
        end
        k_nxt = k_r - 1'b1;
      end
      // replace an out-of-range day with the first
      OP_CLAMP: begin
        if ((day_r == 17'd0) || not_fits) begin
          day_nxt = 17'd1;
        end
      end
      // advance one month while the day count overruns it; in December of the top year, saturate the day at 31
      OP_WALK: begin
        if (not_fits) begin
          day_nxt = day_r - {12'd0, len};
          if (month_r == MONTH_MAX) begin
            if (year_r == TOP_YEAR) begin
              day_nxt = {12'd0, DAY_MAX};
            end else begin
              year_nxt  = year_r + 16'd1;
              ymod_nxt  = (ymod_low == CYCLE_LAST) ? 16'd0 : ymod_r + 16'd1;
              month_nxt = 4'd1;
            end
          end else begin
            month_nxt = month_r + 4'd1;
          end
        end
      end
      // hand the date to the output register when it is free
      OP_EMIT: begin
        if (!out_busy) begin
          ov_nxt = 1'b1;
          oy_nxt = year_r;
          om_nxt = month_r;
          od_nxt = day_r[4:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r  <= BASE_YEAR;
      ymod_r  <= 16'd0;
      month_r <= 4'd1;
      day_r   <= 17'd1;
      k_r     <= '0;
      add_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      year_r  <= year_nxt;
      ymod_r  <= ymod_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
      k_r     <= k_nxt;
      add_r   <= add_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oy_r <= oy_nxt;
    om_r <= om_nxt;
    od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_year  = oy_r;
  assign out_month = om_r;
  assign out_day   = od_r;

endmodule

>>> src/calendar_date_set_and_add_days.sv
// Gregorian date register: one beat in loads a clamped date or adds days; one beat out per item.
// Load: reduce the year modulo 400 in shifted steps, clamp the day, then emit the result.
// Add: the day sum is formed on accept; the month walker steps one month per cycle, up to ~2155 months.
// One item at a time; a done step lies between the output register load and the next accept.
// Synchronous active-low reset sets the date to 2000-01-01 and empties the output register.
`timescale 1ns / 1ps
module calendar_date_set_and_add_days (
  input  logic       clk,
  input  logic       rst_n,
  cdad_in_if.sink    in_ch,
  cdad_out_if.source out_ch
);
  import cdad_pkg::*;

  ctrl_word_t ctrl;
  dp_stat_t   stat;

  cdad_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  cdad_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .stat         (stat),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_opcode    (in_ch.opcode),
    .in_set_year  (in_ch.set_year),
    .in_set_month (in_ch.set_month),
    .in_set_day   (in_ch.set_day),
    .in_add_count (in_ch.add_count),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_year     (out_ch.out_year),
    .out_month    (out_ch.out_month),
    .out_day      (out_ch.out_day)
  );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the Gregorian date register with load and add-days beats.
`timescale 1ns / 1ps
module testbench;
  import cdad_pkg::*;

  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_ADD  = 1'b1;
  localparam int   DRAIN_CYCLES = 20;
  localparam int   STALL_LIMIT  = 10000;  // worst add walks ~2155 months plus stalls
  localparam int unsigned MONTH_DAYS [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } cal_date_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] set_year;
    logic [7:0]  set_month;
    logic [7:0]  set_day;
    logic [15:0] add_count;
  } date_cmd_t;

  logic clk;
  logic rst_n;

  cdad_in_if  in_ch ();
  cdad_out_if out_ch ();

  calendar_date_set_and_add_days DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cal_date_t cur_date;        // predicted stored date
  cal_date_t date_q[$];       // dates still owed by the block
  int        err_count;
  int        quiet_cycles;
  int        rx_hold;
  bit        pace_random;

  // Gregorian leap rule on the full year
  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_len(input int unsigned m, input int unsigned y);
    if (m == 2 && leap_year(y))
      return 29;
    return MONTH_DAYS[m];
  endfunction

  // Compute the date the block holds after one beat
  function automatic cal_date_t predict_date(input cal_date_t cur, input date_cmd_t c);
    int unsigned y;
    int unsigned m;
    int unsigned d;
    cal_date_t   nxt;
    if (c.opcode == OPC_LOAD) begin
      y = 32'(c.set_year);
      m = 32'(c.set_month);
      d = 32'(c.set_day);
      if (y < BASE_YEAR) y = 32'(BASE_YEAR);
      if (m < 1 || m > MONTH_MAX) m = 1;
      if (d < 1 || d > month_len(m, y)) d = 1;
    end else begin
      y = 32'(cur.year);
      m = 32'(cur.month);
      d = 32'(cur.day) + 32'(c.add_count);
      // Carry whole months; saturate past the top year
      while (d > month_len(m, y)) begin
        d = d - month_len(m, y);
        m = m + 1;
        if (m > MONTH_MAX) begin
          if (y >= TOP_YEAR) begin
            m = 32'(MONTH_MAX);
            d = 32'(DAY_MAX);
            break;
          end
          y = y + 1;
          m = 1;
        end
      end
    end
    nxt.year  = y[15:0];
    nxt.month = m[3:0];
    nxt.day   = d[4:0];
    return nxt;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!pace_random || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Drive one input beat and record the date it should produce
  task automatic send_cmd(input date_cmd_t c);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= c.opcode;
    in_ch.set_year  <= c.set_year;
    in_ch.set_month <= c.set_month;
    in_ch.set_day   <= c.set_day;
    in_ch.add_count <= c.add_count;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cur_date = predict_date(cur_date, c);
    date_q.push_back(cur_date);
  endtask

  // Load beat; the count field carries noise
  task automatic load_date(input logic [15:0] y, input logic [7:0] m, input logic [7:0] d);
    date_cmd_t c;
    c.opcode    = OPC_LOAD;
    c.set_year  = y;
    c.set_month = m;
    c.set_day   = d;
    c.add_count = 16'($urandom_range(0, 65535));
    send_cmd(c);
  endtask

  // Add beat; the load fields carry noise
  task automatic add_days(input logic [15:0] n);
    date_cmd_t c;
    c.opcode    = OPC_ADD;
    c.set_year  = 16'($urandom_range(0, 65535));
    c.set_month = 8'($urandom_range(0, 255));
    c.set_day   = 8'($urandom_range(0, 255));
    c.add_count = n;
    send_cmd(c);
  endtask

  function automatic date_cmd_t random_cmd();
    date_cmd_t c;
    int r;
    c.set_year  = 16'($urandom_range(0, 65535));
    c.set_month = 8'($urandom_range(0, 255));
    c.set_day   = 8'($urandom_range(0, 255));
    c.add_count = 16'($urandom_range(0, 65535));
    c.opcode    = ($urandom_range(0, 99) < 40) ? OPC_LOAD : OPC_ADD;
    if (c.opcode == OPC_LOAD) begin
      // Mostly plausible dates, some near the top year, some garbage
      r = $urandom_range(0, 99);
      if (r < 60)      c.set_year = 16'($urandom_range(2000, 2400));
      else if (r < 75) c.set_year = 16'($urandom_range(65400, 65535));
      else if (r < 85) c.set_year = 16'($urandom_range(0, 1999));
      if ($urandom_range(0, 99) < 80) c.set_month = 8'($urandom_range(1, 12));
      if ($urandom_range(0, 99) < 80) c.set_day = 8'($urandom_range(1, 31));
    end else begin
      // Keep most counts small so long month walks stay rare
      r = $urandom_range(0, 99);
      if (r < 50)      c.add_count = 16'($urandom_range(0, 40));
      else if (r < 80) c.add_count = 16'($urandom_range(0, 800));
      else if (r >= 96) c.add_count = 16'hFFFF;
    end
    return c;
  endfunction

  // Lower valid and wait for every owed date, then let the block settle
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (date_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_date();
    add_days(16'd0);
  endtask

  task automatic test_load_clamping();
    load_date(16'd0, 8'd0, 8'd0);
    load_date(16'd1999, 8'd12, 8'd31);
    load_date(16'hFFFF, 8'hFF, 8'hFF);
    load_date(16'd2024, 8'd13, 8'd15);
    load_date(16'd2023, 8'd4, 8'd31);
    load_date(16'd2000, 8'd2, 8'd29);
    load_date(16'd2100, 8'd2, 8'd29);
    load_date(16'd2004, 8'd2, 8'd29);
    load_date(16'd2001, 8'd2, 8'd29);
    load_date(16'd2023, 8'd12, 8'd31);
  endtask

  task automatic test_add_carry();
    load_date(16'd2000, 8'd2, 8'd28);
    add_days(16'd1);
    load_date(16'd2100, 8'd2, 8'd28);
    add_days(16'd1);
    load_date(16'd2023, 8'd12, 8'd31);
    add_days(16'd1);
    add_days(16'd0);
    load_date(16'd2000, 8'd1, 8'd1);
    add_days(16'hFFFF);
  endtask

  task automatic test_year_saturation();
    load_date(16'hFFFF, 8'd12, 8'd1);
    add_days(16'd30);
    add_days(16'd1);
    load_date(16'd65530, 8'd6, 8'd15);
    add_days(16'hFFFF);
  endtask

  task automatic test_ignored_fields();
    date_cmd_t c;
    c = '1;
    c.opcode = OPC_LOAD;
    c.set_year = 16'd2012;
    c.set_month = 8'd7;
    c.set_day = 8'd4;
    send_cmd(c);
    c = '1;
    c.opcode = OPC_ADD;
    c.add_count = 16'd5;
    send_cmd(c);
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 270; i++) begin
      // Switch between paced and back-to-back stretches
      if (i % 45 == 0) pace_random = ($urandom_range(0, 3) != 0);
      send_cmd(random_cmd());
    end
  endtask

  // Result side stalls
  always @(negedge clk) begin
    if (rx_hold == 0) rx_hold = pick_gap();
    if (rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest owed date
  always @(posedge clk) begin
    cal_date_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (date_q.size() == 0) begin
        $display("%0t: unexpected result %0d-%0d-%0d", $time,
                 out_ch.out_year, out_ch.out_month, out_ch.out_day);
        err_count++;
      end else begin
        want = date_q.pop_front();
        if (out_ch.out_year !== want.year) begin
          $display("%0t: year mismatch, expected %0d, actual %0d", $time,
                   want.year, out_ch.out_year);
          err_count++;
        end
        if (out_ch.out_month !== want.month) begin
          $display("%0t: month mismatch, expected %0d, actual %0d", $time,
                   want.month, out_ch.out_month);
          err_count++;
        end
        if (out_ch.out_day !== want.day) begin
          $display("%0t: day mismatch, expected %0d, actual %0d", $time,
                   want.day, out_ch.out_day);
          err_count++;
        end
      end
    end
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OPC_LOAD;
    in_ch.set_year  = '0;
    in_ch.set_month = '0;
    in_ch.set_day   = '0;
    in_ch.add_count = '0;
    out_ch.ready    = 1'b0;
    err_count       = 0;
    quiet_cycles    = 0;
    rx_hold         = 0;
    pace_random     = 1'b0;
    cur_date.year   = BASE_YEAR;
    cur_date.month  = 4'd1;
    cur_date.day    = 5'd1;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_date();
    test_load_clamping();
    pace_random = 1'b1;
    test_add_carry();
    test_year_saturation();
    test_ignored_fields();
    test_random_mix();
    drain_results();

    if (err_count == 0 && date_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
